FILE: hdl/halton_point_generator_core_defines.svh
// ---------------------------------------------------------------------------
// Halton point generator assertion macros
// Shared property wrappers, clocked on clk_i and disabled during reset.
// ---------------------------------------------------------------------------
`ifndef HALTON_POINT_GENERATOR_CORE_DEFINES_SVH
`define HALTON_POINT_GENERATOR_CORE_DEFINES_SVH

// same-cycle implication
`define HPG_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define HPG_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/hpg_pkg.sv
// ---------------------------------------------------------------------------
// Halton point generator package
// Payload types, register and request codes, prime and reciprocal tables.
// ---------------------------------------------------------------------------
package hpg_pkg;

  localparam int MAX_DIM_DEF    = 8;
  localparam int MAX_POINTS_DEF = 8;
  localparam int FRAC_BITS_DEF  = 32;

  localparam int IDX_W   = 32;
  localparam int VALUE_W = 32;
  localparam int BASE_W  = 5;
  // b^n < 19 * 2^32 for every base and index
  localparam int NUM_W   = 37;
  localparam int CFG_W   = 32;

  // register indexes
  localparam logic [1:0] CFG_SCRAMBLE = 2'd0;
  localparam logic [1:0] CFG_SEED     = 2'd1;
  localparam logic [1:0] CFG_DIM      = 2'd2;

  localparam logic SCR_NONE    = 1'b0;
  localparam logic SCR_REVERSE = 1'b1;

  localparam logic REQ_CONTINUE = 1'b0;
  localparam logic REQ_RESTART  = 1'b1;

  typedef struct packed {
    logic       req_type;
    logic [3:0] points;
  } in_item_t;

  typedef struct packed {
    logic [2:0]         point_offset;
    logic [2:0]         coordinate;
    logic [VALUE_W-1:0] value;
    logic               last;
  } out_item_t;

  function automatic logic [BASE_W-1:0] prime_base(input logic [2:0] k);
    logic [BASE_W-1:0] b;
    unique case (k)
      3'd0: b = 5'd2;
      3'd1: b = 5'd3;
      3'd2: b = 5'd5;
      3'd3: b = 5'd7;
      3'd4: b = 5'd11;
      3'd5: b = 5'd13;
      3'd6: b = 5'd17;
      3'd7: b = 5'd19;
      default: b = 5'd2;
    endcase
    return b;
  endfunction

  // floor(2^32 / b)
  function automatic logic [IDX_W-1:0] prime_recip(input logic [2:0] k);
    logic [IDX_W-1:0] m;
    unique case (k)
      3'd0: m = 32'h8000_0000;
      3'd1: m = 32'h5555_5555;
      3'd2: m = 32'h3333_3333;
      3'd3: m = 32'h2492_4924;
      3'd4: m = 32'h1745_D174;
      3'd5: m = 32'h13B1_3B13;
      3'd6: m = 32'h0F0F_0F0F;
      3'd7: m = 32'h0D79_435E;
      default: m = 32'h8000_0000;
    endcase
    return m;
  endfunction

endpackage

FILE: hdl/halton_point_generator_core.sv
// Per coordinate: a multiply step and a digit step for each base-b digit of the index
// (ceil(log_b(idx+1)) digits), a setup step, a long division of FRAC_BITS bits and the output load.
// A request of P points and D dimensions is accepted, then its P*D coordinates are done in turn,
// by one shared reciprocal multiplier and one compare/subtract; output stalls hold the output load.
// One request at a time; in_ready_o is high only between requests.
// Reset: scramble 0, seed 0, dimension 1, sequence index 0, no output pending.
// ---------------------------------------------------------------------------
// Halton point generator core
// Radical inverse of a running index in the first eight prime bases, with
// optional digit reversal, emitted as truncated unsigned fractions.
// ---------------------------------------------------------------------------
`include "halton_point_generator_core_defines.svh"

module halton_point_generator_core
  import hpg_pkg::*;
#(
  parameter int MAX_DIM    = MAX_DIM_DEF,
  parameter int MAX_POINTS = MAX_POINTS_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [1:0]       cfg_idx_i,
  input  logic [CFG_W-1:0] cfg_wdata_i,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  in_item_t         in_data_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output out_item_t        out_data_o
);

  localparam int BIT_W = $clog2(FRAC_BITS + 1);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_MUL  = 3'd1;
  localparam logic [2:0] ST_DIG  = 3'd2;
  localparam logic [2:0] ST_DIV  = 3'd3;
  localparam logic [2:0] ST_EMIT = 3'd4;

  logic [2:0]           state_q, state_d;
  logic [IDX_W-1:0]     idx_q, idx_d;
  logic                 scr_q, scr_d;
  logic [IDX_W-1:0]     seed_q, seed_d;
  logic [3:0]           dim_q, dim_d;
  logic                 out_valid_q, out_valid_d;
  out_item_t            out_q, out_d;

  logic [3:0]           pts_q, pts_d;
  logic [3:0]           dims_q, dims_d;
  logic [2:0]           pt_q, pt_d;
  logic [2:0]           coord_q, coord_d;
  logic [IDX_W-1:0]     rest_q, rest_d;
  logic [2*IDX_W-1:0]   prod_q, prod_d;
  logic [NUM_W-1:0]     num_q, num_d;
  logic [NUM_W-1:0]     den_q, den_d;
  logic [VALUE_W-1:0]   frac_q, frac_d;
  logic [BIT_W-1:0]     bit_q, bit_d;

  logic [BASE_W-1:0]    base;
  logic [IDX_W-1:0]     recip;
  logic [IDX_W-1:0]     q_est, q_fix, r_est, r_fix;
  logic [BASE_W-1:0]    digit;
  logic [NUM_W:0]       shifted;
  logic                 sub_ok;
  logic                 in_fire, emit_go, coord_last, pt_last;
  logic [IDX_W-1:0]     idx_sel;
  logic [3:0]           pts_clamp, dims_clamp;

  assign base  = prime_base(coord_q);
  assign recip = prime_recip(coord_q);

  // digit step: quotient estimate is exact or one low
  assign q_est = prod_q[2*IDX_W-1:IDX_W];
  assign r_est = rest_q - IDX_W'(q_est * IDX_W'(base));
  always_comb begin
    if (r_est >= IDX_W'(base)) begin
      q_fix = q_est + IDX_W'(1);
      r_fix = r_est - IDX_W'(base);
    end else begin
      q_fix = q_est;
      r_fix = r_est;
    end
    digit = r_fix[BASE_W-1:0];
    if (scr_q == SCR_REVERSE && digit != '0) begin
      digit = base - digit;
    end
  end

  assign shifted = {num_q, 1'b0};
  assign sub_ok  = shifted >= {1'b0, den_q};

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign emit_go    = (state_q == ST_EMIT) && (!out_valid_q || out_ready_i);
  assign coord_last = ({1'b0, coord_q} + 4'd1) == dims_q;
  assign pt_last    = ({1'b0, pt_q} + 4'd1) == pts_q;

  assign idx_sel   = (in_data_i.req_type == REQ_RESTART) ? seed_q : idx_q;
  assign pts_clamp = (in_data_i.points > 4'(MAX_POINTS)) ? 4'(MAX_POINTS) : in_data_i.points;
  always_comb begin
    if (dim_q == 4'd0) begin
      dims_clamp = 4'd1;
    end else if (dim_q > 4'(MAX_DIM)) begin
      dims_clamp = 4'(MAX_DIM);
    end else begin
      dims_clamp = dim_q;
    end
  end

  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    scr_d       = scr_q;
    seed_d      = seed_q;
    dim_d       = dim_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;
    pts_d       = pts_q;
    dims_d      = dims_q;
    pt_d        = pt_q;
    coord_d     = coord_q;
    rest_d      = rest_q;
    prod_d      = prod_q;
    num_d       = num_q;
    den_d       = den_q;
    frac_d      = frac_q;
    bit_d       = bit_q;

    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_SCRAMBLE: scr_d  = cfg_wdata_i[0];
        CFG_SEED:     seed_d = cfg_wdata_i[IDX_W-1:0];
        CFG_DIM:      dim_d  = cfg_wdata_i[3:0];
        default: ;
      endcase
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          idx_d   = idx_sel;
          pts_d   = pts_clamp;
          dims_d  = dims_clamp;
          pt_d    = '0;
          coord_d = '0;
          rest_d  = idx_sel;
          num_d   = '0;
          den_d   = NUM_W'(1);
          if (pts_clamp != 4'd0) begin
            state_d = ST_MUL;
          end
        end
      end
      ST_MUL: begin
        if (rest_q == '0) begin
          frac_d  = '0;
          bit_d   = BIT_W'(FRAC_BITS);
          state_d = ST_DIV;
        end else begin
          prod_d  = (2*IDX_W)'(rest_q) * (2*IDX_W)'(recip);
          state_d = ST_DIG;
        end
      end
      ST_DIG: begin
        rest_d  = q_fix;
        num_d   = NUM_W'(num_q * NUM_W'(base)) + NUM_W'(digit);
        den_d   = NUM_W'(den_q * NUM_W'(base));
        state_d = ST_MUL;
      end
      ST_DIV: begin
        if (sub_ok) begin
          num_d = NUM_W'(shifted - {1'b0, den_q});
        end else begin
          num_d = shifted[NUM_W-1:0];
        end
        frac_d = {frac_q[VALUE_W-2:0], sub_ok};
        bit_d  = bit_q - BIT_W'(1);
        if (bit_q == BIT_W'(1)) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (emit_go) begin
          out_valid_d        = 1'b1;
          out_d.point_offset = pt_q;
          out_d.coordinate   = coord_q;
          out_d.value        = frac_q;
          out_d.last         = pt_last && coord_last;
          num_d              = '0;
          den_d              = NUM_W'(1);
          if (coord_last) begin
            coord_d = '0;
            pt_d    = pt_q + 3'd1;
            idx_d   = idx_q + IDX_W'(1);
            rest_d  = idx_q + IDX_W'(1);
          end else begin
            coord_d = coord_q + 3'd1;
            rest_d  = idx_q;
          end
          state_d = (pt_last && coord_last) ? ST_IDLE : ST_MUL;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      idx_q       <= '0;
      scr_q       <= SCR_NONE;
      seed_q      <= '0;
      dim_q       <= 4'd1;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      scr_q       <= scr_d;
      seed_q      <= seed_d;
      dim_q       <= dim_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q   <= out_d;
    pts_q   <= pts_d;
    dims_q  <= dims_d;
    pt_q    <= pt_d;
    coord_q <= coord_d;
    rest_q  <= rest_d;
    prod_q  <= prod_d;
    num_q   <= num_d;
    den_q   <= den_d;
    frac_q  <= frac_d;
    bit_q   <= bit_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `HPG_ASSERT_NOW(a_digit_lt_base, state_q == ST_DIG, r_fix < IDX_W'(base), "digit not below base")
  `HPG_ASSERT_NOW(a_num_lt_den, state_q == ST_MUL || state_q == ST_DIV, num_q < den_q, "fraction numerator not below denominator")
  `HPG_ASSERT_NEXT(a_last_to_idle, emit_go && pt_last && coord_last, state_q == ST_IDLE && out_valid_q && out_q.last, "final coordinate did not end the request")

endmodule
